[hdl/srtvp_pkg.sv]
// Shared constants, codes and types of the turn velocity profile block.
`timescale 1ns / 1ps
`default_nettype none
package srtvp_pkg;

  localparam int unsigned TICK_HZ_DEF = 1000;
  localparam int unsigned DEPTH_DEF   = 256;
  localparam int TICK_W  = 17;
  localparam int DEPTH_W = 13;

  localparam logic [23:0] MAX24    = 24'hFFFFFF;
  localparam logic [16:0] PIH_Q16  = 17'd102944;
  localparam logic [16:0] SINE_ONE = 17'd65536;
  localparam logic [23:0] GAIN_RST = 24'd4096;
  localparam logic [19:0] CAP_RST  = 20'd40960;

  localparam logic CFG_GAIN = 1'b0;
  localparam logic CFG_CAP  = 1'b1;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Controller states; the datapath runs the step named by the state.
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_PACC  = 5'd1;
  localparam logic [4:0] ST_PPROD = 5'd2;
  localparam logic [4:0] ST_PSQS  = 5'd3;
  localparam logic [4:0] ST_PSQW  = 5'd4;
  localparam logic [4:0] ST_PRM1  = 5'd5;
  localparam logic [4:0] ST_PRM2  = 5'd6;
  localparam logic [4:0] ST_PRDS  = 5'd7;
  localparam logic [4:0] ST_PRDW  = 5'd8;
  localparam logic [4:0] ST_PTR1  = 5'd9;
  localparam logic [4:0] ST_PTDS  = 5'd10;
  localparam logic [4:0] ST_PTDW  = 5'd11;
  localparam logic [4:0] ST_PCR1  = 5'd12;
  localparam logic [4:0] ST_PCDS  = 5'd13;
  localparam logic [4:0] ST_PCDW  = 5'd14;
  localparam logic [4:0] ST_PFIN  = 5'd15;
  localparam logic [4:0] ST_TEVAL = 5'd16;
  localparam logic [4:0] ST_TKM   = 5'd17;
  localparam logic [4:0] ST_TKDS  = 5'd18;
  localparam logic [4:0] ST_TKDW  = 5'd19;
  localparam logic [4:0] ST_TZM   = 5'd20;
  localparam logic [4:0] ST_TZ2   = 5'd22;
  localparam logic [4:0] ST_THORN = 5'd23;
  localparam logic [4:0] ST_TSIN  = 5'd24;
  localparam logic [4:0] ST_TMAG  = 5'd25;
  localparam logic [4:0] ST_EMIT  = 5'd26;

  localparam logic [1:0] TK_DONE   = 2'd0;
  localparam logic [1:0] TK_CRUISE = 2'd1;
  localparam logic [1:0] TK_SINE   = 2'd2;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] coef;
    logic       accept;
  } cmd_t;

  typedef struct packed {
    logic       sqrt_done;
    logic       div_done;
    logic       zero_plan;
    logic       capped;
    logic [1:0] tick_kind;
    logic       out_busy;
  } stat_t;

  // Horner coefficients of the sine polynomial, innermost first.
  function automatic logic [16:0] horner_coef(input logic [1:0] idx);
    logic [16:0] c;
    case (idx)
      2'd0:    c = 17'd307;
      2'd1:    c = 17'd5223;
      2'd2:    c = 17'd42334;
      default: c = 17'd102944;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[hdl/srtvp_if.sv]
// Valid/ready channels for input and result words.
`timescale 1ns / 1ps
`default_nettype none
interface srtvp_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [15:0] turn_angle;
  logic [15:0]        force_req;
  modport source(output valid, command, turn_angle, force_req, input ready);
  modport sink(input valid, command, turn_angle, force_req, output ready);
endinterface

interface srtvp_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] turn_rate;
  logic               turn_done;
  modport source(output valid, turn_rate, turn_done, input ready);
  modport sink(input valid, turn_rate, turn_done, output ready);
endinterface
`default_nettype wire

[hdl/srtvp_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module srtvp_div
  import srtvp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [47:0] den,
  output logic             done,
  output logic [63:0]      quo
);
  logic [63:0] n;
  logic [47:0] rem;
  logic [47:0] den_r;
  logic [5:0]  cnt;
  logic        busy;
  logic [48:0] remc;
  logic [48:0] diff;
  logic        ge;

  assign remc = {rem, n[63]};
  assign diff = remc - {1'b0, den_r};
  assign ge   = remc >= {1'b0, den_r};
  assign quo  = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient bits shift into the numerator register as it empties.
  always_ff @(posedge clk) begin
    if (start) begin
      n     <= num;
      den_r <= den;
      rem   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[47:0] : remc[47:0];
      n   <= {n[62:0], ge};
    end
  end
endmodule
`default_nettype wire

[hdl/srtvp_sqrt.sv]
// Integer square root, one root bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module srtvp_sqrt
  import srtvp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] radicand,
  output logic             done,
  output logic [23:0]      root
);
  logic [47:0] v;
  logic [25:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [27:0] remc;
  logic [27:0] trial;
  logic [27:0] diff;
  logic        ge;

  assign remc  = {rem, v[47:46]};
  assign trial = {2'b00, root, 2'b01};
  assign diff  = remc - trial;
  assign ge    = remc >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      v    <= {v[45:0], 2'b00};
      rem  <= ge ? diff[25:0] : remc[25:0];
      root <= {root[22:0], ge};
    end
  end
endmodule
`default_nettype wire

[hdl/srtvp_dp.sv]
// Datapath: turn plan registers, shared multiplier, divider, root unit, output word.
`timescale 1ns / 1ps
`default_nettype none
module srtvp_dp
  import srtvp_pkg::*;
#(
  parameter int unsigned TICK_HZ          = TICK_HZ_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  input  wire logic               in_command,
  input  wire logic signed [15:0] in_angle,
  input  wire logic [15:0]        in_force,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [23:0]        cfg_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [20:0]      out_vel,
  output logic                    out_done
);
  localparam logic [TICK_W-1:0]  TickC  = TICK_W'(TICK_HZ);
  localparam logic [DEPTH_W-1:0] DepthC = DEPTH_W'(SINE_TABLE_DEPTH);
  // Rounded-up 2^40 / depth; (k * ZScaleC) >> 24 equals floor(k * 65536 / depth) exactly
  // for every k up to the table depth.
  localparam logic [35:0] ZScaleC = 36'(((64'd1 << 40) + 64'(SINE_TABLE_DEPTH) - 64'd1) /
                                        64'(SINE_TABLE_DEPTH));

  logic [23:0] gain;
  logic [19:0] vcap;
  logic [15:0] agl;
  logic [15:0] force_q;
  logic        neg;
  logic [31:0] accel;
  logic [63:0] x;
  logic [19:0] peak;
  logic        capped;
  logic [23:0] ramp;
  logic [23:0] cruise;
  logic [23:0] elapsed;
  logic        turning;
  logic [23:0] u;
  logic [12:0] k;
  logic [16:0] z;
  logic [16:0] z2;
  logic [16:0] r;
  logic [16:0] s;
  logic [19:0] res_mag;
  logic        res_done;

  logic [39:0] mul_a;
  logic [23:0] mul_b;
  logic [63:0] prod;
  logic        div_start;
  logic [63:0] div_num;
  logic [47:0] div_den;
  logic        div_done;
  logic [63:0] quo;
  logic        sqrt_done;
  logic [23:0] root;
  logic [25:0] total_raw;
  logic [23:0] total;
  logic [24:0] rc_sum;
  logic [1:0]  kind;
  logic [23:0] sine_num;
  logic [23:0] quo_sat;
  logic [48:0] two_trans;
  logic [15:0] cruise_span;
  logic [23:0] elapsed_inc;
  logic [17:0] s_raw;
  logic [63:0] mag_round;
  logic        out_busy;

  assign total_raw   = {1'b0, ramp, 1'b0} + {2'b00, cruise};
  assign total       = (total_raw > {2'b00, MAX24}) ? MAX24 : total_raw[23:0];
  assign rc_sum      = {1'b0, ramp} + {1'b0, cruise};
  assign quo_sat     = (|quo[63:24]) ? MAX24 : quo[23:0];
  assign two_trans   = {quo[47:0], 1'b0};
  assign cruise_span = ({33'd0, agl} > two_trans) ? (agl - two_trans[15:0]) : 16'd0;
  assign elapsed_inc = (elapsed != MAX24) ? (elapsed + 24'd1) : elapsed;
  assign s_raw       = prod[33:16];
  assign mag_round   = prod + 64'd32768;
  assign out_busy    = out_valid && !out_ready;

  // Which part of the profile the current tick falls in.
  always_comb begin
    kind     = TK_CRUISE;
    sine_num = elapsed;
    if (!turning || elapsed >= total) begin
      kind = TK_DONE;
    end else if (elapsed < ramp) begin
      kind = TK_SINE;
    end else if ({1'b0, elapsed} >= rc_sum) begin
      kind     = TK_SINE;
      sine_num = total - elapsed;
    end
  end

  always_comb begin
    stat.sqrt_done = sqrt_done;
    stat.div_done  = div_done;
    stat.zero_plan = (peak == 20'd0) || (accel == 32'd0);
    stat.capped    = capped;
    stat.tick_kind = kind;
    stat.out_busy  = out_busy;
  end

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      ST_PACC:  begin mul_a = {24'd0, force_q};      mul_b = gain;                 end
      ST_PPROD: begin mul_a = {8'd0, accel};         mul_b = {8'd0, agl};          end
      ST_PRM1:  begin mul_a = {20'd0, peak};         mul_b = {7'd0, TickC};        end
      ST_PRM2:  begin mul_a = x[39:0];               mul_b = {7'd0, PIH_Q16};      end
      ST_PTR1:  begin mul_a = {20'd0, peak};         mul_b = {4'd0, peak};         end
      ST_PCR1:  begin mul_a = x[39:0];               mul_b = {7'd0, TickC};        end
      ST_TKM:   begin mul_a = {16'd0, u};            mul_b = {11'd0, DepthC};      end
      ST_TZM:   begin mul_a = {4'd0, ZScaleC};       mul_b = {11'd0, k};           end
      ST_TZ2:   begin mul_a = {23'd0, z};            mul_b = {7'd0, z};            end
      ST_THORN: begin mul_a = {23'd0, z2};           mul_b = {7'd0, r};            end
      ST_TSIN:  begin mul_a = {23'd0, z};            mul_b = {7'd0, r};            end
      ST_TMAG:  begin mul_a = {20'd0, peak};         mul_b = {7'd0, s};            end
      default:  begin mul_a = '0;                    mul_b = '0;                   end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Divider operands; each rounded quotient adds half the divisor first.
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      ST_PRDS: begin
        div_num = x + {17'd0, accel, 15'd0};
        div_den = {accel, 16'd0};
      end
      ST_PTDS: begin
        div_num = x;
        div_den = {16'd0, accel};
      end
      ST_PCDS: begin
        div_num = x + {45'd0, peak[19:1]};
        div_den = {28'd0, peak};
      end
      ST_TKDS: begin
        div_num = x + {41'd0, ramp[23:1]};
        div_den = {24'd0, ramp};
      end
      default: div_start = 1'b0;
    endcase
  end

  srtvp_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (quo)
  );

  srtvp_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.op == ST_PSQS),
    .radicand(x[47:0]),
    .done    (sqrt_done),
    .root    (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gain    <= GAIN_RST;
      vcap    <= CAP_RST;
      ramp    <= '0;
      cruise  <= '0;
      peak    <= '0;
      elapsed <= '0;
      turning <= 1'b0;
      neg     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN: gain <= cfg_data;
          default:  vcap <= cfg_data[19:0];
        endcase
      end
      case (cmd.op)
        ST_IDLE: begin
          if (cmd.accept && in_command == CMD_START) begin
            neg     <= in_angle[15];
            agl     <= in_angle[15] ? 16'(-in_angle) : in_angle;
            force_q <= in_force;
          end
        end
        ST_PACC: begin
          accel  <= prod[39:8];
          ramp   <= '0;
          cruise <= '0;
        end
        ST_PPROD: x <= {1'b0, prod[63:1]};
        ST_PSQW: begin
          if (sqrt_done) begin
            if (root > {4'd0, vcap}) begin
              peak   <= vcap;
              capped <= 1'b1;
            end else begin
              peak   <= root[19:0];
              capped <= 1'b0;
            end
          end
        end
        ST_PRM1, ST_PRM2, ST_PTR1, ST_PCR1, ST_TKM: x <= prod;
        ST_PRDW: if (div_done) ramp <= quo_sat;
        ST_PTDW: if (div_done) x <= {48'd0, cruise_span};
        ST_PCDW: if (div_done) cruise <= quo_sat;
        ST_PFIN: begin
          elapsed  <= '0;
          turning  <= 1'b1;
          res_mag  <= '0;
          res_done <= 1'b0;
        end
        ST_TEVAL: begin
          case (kind)
            TK_DONE: begin
              turning  <= 1'b0;
              res_mag  <= '0;
              res_done <= 1'b1;
            end
            TK_CRUISE: begin
              elapsed  <= elapsed_inc;
              res_mag  <= peak;
              res_done <= 1'b0;
            end
            default: begin
              elapsed <= elapsed_inc;
              u       <= sine_num;
            end
          endcase
        end
        ST_TKDW: if (div_done) k <= quo[12:0];
        ST_TZM:  z <= prod[40:24];
        ST_TZ2: begin
          z2 <= prod[32:16];
          r  <= 17'd11;
        end
        ST_THORN: r <= horner_coef(cmd.coef) - prod[32:16];
        ST_TSIN:  s <= (s_raw > {1'b0, SINE_ONE}) ? SINE_ONE : s_raw[16:0];
        ST_TMAG: begin
          res_mag  <= mag_round[35:16];
          res_done <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Output word register; it holds until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == ST_EMIT && !out_busy) begin
      out_valid <= 1'b1;
      out_vel   <= neg ? -$signed({1'b0, res_mag}) : $signed({1'b0, res_mag});
      out_done  <= res_done;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

[hdl/srtvp_ctrl.sv]
// Controller: sequences the plan and tick steps of the datapath.
`timescale 1ns / 1ps
`default_nettype none
module srtvp_ctrl
  import srtvp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  in_command,
  input  wire stat_t stat,
  output cmd_t       cmd
);
  logic [4:0] state;
  logic [4:0] state_next;
  logic [1:0] hstep;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd.op     = state;
    cmd.coef   = hstep;
    cmd.accept = in_valid && (state == ST_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = (in_command == CMD_START) ? ST_PACC : ST_TEVAL;
      end
      ST_PACC:  state_next = ST_PPROD;
      ST_PPROD: state_next = ST_PSQS;
      ST_PSQS:  state_next = ST_PSQW;
      ST_PSQW:  if (stat.sqrt_done) state_next = ST_PRM1;
      ST_PRM1:  state_next = stat.zero_plan ? ST_PFIN : ST_PRM2;
      ST_PRM2:  state_next = ST_PRDS;
      ST_PRDS:  state_next = ST_PRDW;
      ST_PRDW:  if (stat.div_done) state_next = stat.capped ? ST_PTR1 : ST_PFIN;
      ST_PTR1:  state_next = ST_PTDS;
      ST_PTDS:  state_next = ST_PTDW;
      ST_PTDW:  if (stat.div_done) state_next = ST_PCR1;
      ST_PCR1:  state_next = ST_PCDS;
      ST_PCDS:  state_next = ST_PCDW;
      ST_PCDW:  if (stat.div_done) state_next = ST_PFIN;
      ST_PFIN:  state_next = ST_EMIT;
      ST_TEVAL: state_next = (stat.tick_kind == TK_SINE) ? ST_TKM : ST_EMIT;
      ST_TKM:   state_next = ST_TKDS;
      ST_TKDS:  state_next = ST_TKDW;
      ST_TKDW:  if (stat.div_done) state_next = ST_TZM;
      ST_TZM:   state_next = ST_TZ2;
      ST_TZ2:   state_next = ST_THORN;
      ST_THORN: if (hstep == 2'd3) state_next = ST_TSIN;
      ST_TSIN:  state_next = ST_TMAG;
      ST_TMAG:  state_next = ST_EMIT;
      ST_EMIT:  if (!stat.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hstep <= '0;
    end else begin
      state <= state_next;
      hstep <= (state == ST_THORN) ? hstep + 2'd1 : 2'd0;
    end
  end
endmodule
`default_nettype wire

[hdl/sine_ramp_turn_velocity_profile.sv]
// A start word runs a 24-step root, then three 64-step divisions when the cap acts, one when
// it does not and none for a zero plan. A tick word in a ramp runs one 64-step division and
// nine multiplies; a cruise, finished or idle tick runs neither. One word is worked on at a
// time; the next is accepted the cycle after its result is loaded, and a result still waiting
// in the output register stretches that.
// Synchronous active-high reset restores the register defaults and an idle, empty plan.
`timescale 1ns / 1ps
`default_nettype none
module sine_ramp_turn_velocity_profile
  import srtvp_pkg::*;
#(
  parameter int unsigned TICK_HZ          = TICK_HZ_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  srtvp_in_if.sink         in_ch,
  srtvp_out_if.source      out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);
  cmd_t  cmd;
  stat_t stat;
  logic  in_rdy;

  assign in_ch.ready = in_rdy;

  srtvp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_rdy),
    .in_command(in_ch.command),
    .stat      (stat),
    .cmd       (cmd)
  );

  srtvp_dp #(
    .TICK_HZ         (TICK_HZ),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_command(in_ch.command),
    .in_angle  (in_ch.turn_angle),
    .in_force  (in_ch.force_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_vel   (out_ch.turn_rate),
    .out_done  (out_ch.turn_done)
  );
endmodule
`default_nettype wire
